[design/svc_ptc_pkg.sv]
// Package with the transaction types, codes and character tables of the SvcParams checker.
`default_nettype none
package svc_ptc_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  transports;
      logic [15:0] port;
      logic        dohpath_present;
   } rsp_item_type;

   typedef enum logic [2:0] {
      PH_KEY_HI,
      PH_KEY_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_VALUE
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_PARSING,
      VERDICT_UNUSABLE,
      VERDICT_MALFORMED
   } verdict_type;

   localparam logic [1:0] STATUS_USABLE    = 2'd0;
   localparam logic [1:0] STATUS_UNUSABLE  = 2'd1;
   localparam logic [1:0] STATUS_MALFORMED = 2'd2;

   localparam logic [15:0] KEY_ALPN     = 16'd1;
   localparam logic [15:0] KEY_PORT     = 16'd3;
   localparam logic [15:0] KEY_IPV4HINT = 16'd4;
   localparam logic [15:0] KEY_IPV6HINT = 16'd6;
   localparam logic [15:0] KEY_DOHPATH  = 16'd7;

   localparam logic [3:0] TP_DOT = 4'b0001;
   localparam logic [3:0] TP_H2  = 4'b0010;
   localparam logic [3:0] TP_H3  = 4'b0100;
   localparam logic [3:0] TP_DOQ = 4'b1000;

   localparam logic [23:0] ALPN_DOT = 24'h646F74;
   localparam logic [23:0] ALPN_H2  = 24'h006832;
   localparam logic [23:0] ALPN_H3  = 24'h006833;
   localparam logic [23:0] ALPN_DOQ = 24'h646F71;

   // Maps a finished ALPN identifier to the transport bit it names.
   function automatic logic [3:0] classify_alpn(input logic [7:0] id_len,
                                                input logic [23:0] id_bytes);
      logic [3:0] bits;
      bits = 4'b0000;
      if (id_len == 8'd3 && id_bytes == ALPN_DOT) bits = bits | TP_DOT;
      if (id_len == 8'd2 && id_bytes == ALPN_H2)  bits = bits | TP_H2;
      if (id_len == 8'd2 && id_bytes == ALPN_H3)  bits = bits | TP_H3;
      if (id_len == 8'd3 && id_bytes == ALPN_DOQ) bits = bits | TP_DOQ;
      return bits;
   endfunction

   // URI characters (unreserved, reserved) plus the template braces.
   function automatic logic uri_char_ok(input logic [7:0] c);
      logic ok;
      ok = 1'b0;
      if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
      if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
      if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
      case (c)
         8'h2D, 8'h2E, 8'h5F, 8'h7E,
         8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40,
         8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
         8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D,
         8'h7B, 8'h7D: ok = 1'b1;
         default: ;
      endcase
      return ok;
   endfunction

endpackage
`default_nettype wire

[design/svc_ptc_parser.sv]
// Byte-wise SvcParams parser state and the end-of-option verdict.
`default_nettype none
module svc_ptc_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      fire,
   input  wire svc_ptc_pkg::req_item_type item,
   output logic                           rsp_load,
   output svc_ptc_pkg::rsp_item_type      rsp_item
);

   svc_ptc_pkg::phase_type   phase_ff,     phase_in;
   svc_ptc_pkg::verdict_type verdict_ff,   verdict_in;
   logic [15:0]              cur_key_ff,   cur_key_in;
   logic [15:0]              prev_key_ff,  prev_key_in;
   logic [15:0]              val_rem_ff,   val_rem_in;
   logic [7:0]               id_rem_ff,    id_rem_in;
   logic [23:0]              id_bytes_ff,  id_bytes_in;
   logic [7:0]               id_len_ff,    id_len_in;
   logic [3:0]               tp_ff,        tp_in;
   logic [15:0]              port_ff,      port_in;
   logic                     alpn_seen_ff, alpn_seen_in;
   logic                     path_seen_ff, path_seen_in;

   logic [7:0]  b;
   logic [15:0] key_full;
   logic [15:0] len_full;
   logic [15:0] val_dec;
   logic [7:0]  id_dec;
   logic [1:0]  status;

   assign b        = item.data_byte;
   assign key_full = cur_key_ff | {8'd0, b};
   assign len_full = val_rem_ff | {8'd0, b};
   assign val_dec  = val_rem_ff - 16'd1;
   assign id_dec   = id_rem_ff - 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      verdict_in   = verdict_ff;
      cur_key_in   = cur_key_ff;
      prev_key_in  = prev_key_ff;
      val_rem_in   = val_rem_ff;
      id_rem_in    = id_rem_ff;
      id_bytes_in  = id_bytes_ff;
      id_len_in    = id_len_ff;
      tp_in        = tp_ff;
      port_in      = port_ff;
      alpn_seen_in = alpn_seen_ff;
      path_seen_in = path_seen_ff;
      rsp_load     = 1'b0;
      rsp_item     = '0;
      status       = svc_ptc_pkg::STATUS_USABLE;

      if (fire && item.byte_present && verdict_ff == svc_ptc_pkg::VERDICT_PARSING) begin
         case (phase_ff)
            svc_ptc_pkg::PH_KEY_LO: begin
               cur_key_in = key_full;
               if (key_full <= prev_key_ff) begin
                  verdict_in = svc_ptc_pkg::VERDICT_MALFORMED;
               end else begin
                  prev_key_in = key_full;
                  phase_in    = svc_ptc_pkg::PH_LEN_HI;
               end
            end
            svc_ptc_pkg::PH_LEN_HI: begin
               val_rem_in = {b, 8'd0};
               phase_in   = svc_ptc_pkg::PH_LEN_LO;
            end
            svc_ptc_pkg::PH_LEN_LO: begin
               val_rem_in = len_full;
               phase_in   = (len_full != 16'd0) ? svc_ptc_pkg::PH_VALUE
                                                : svc_ptc_pkg::PH_KEY_HI;
               if (cur_key_ff == svc_ptc_pkg::KEY_ALPN) begin
                  if (len_full == 16'd0) begin
                     verdict_in = svc_ptc_pkg::VERDICT_UNUSABLE;
                     phase_in   = phase_ff;
                  end else begin
                     alpn_seen_in = 1'b1;
                     id_rem_in    = 8'd0;
                  end
               end else if (cur_key_ff == svc_ptc_pkg::KEY_PORT) begin
                  if (len_full != 16'd2) begin
                     verdict_in = svc_ptc_pkg::VERDICT_MALFORMED;
                     phase_in   = phase_ff;
                  end
               end else if (cur_key_ff == svc_ptc_pkg::KEY_IPV4HINT ||
                            cur_key_ff == svc_ptc_pkg::KEY_IPV6HINT) begin
                  verdict_in = svc_ptc_pkg::VERDICT_MALFORMED;
                  phase_in   = phase_ff;
               end else if (cur_key_ff == svc_ptc_pkg::KEY_DOHPATH) begin
                  path_seen_in = 1'b1;
               end
            end
            svc_ptc_pkg::PH_VALUE: begin
               val_rem_in = val_dec;
               if (val_dec == 16'd0) begin
                  phase_in = svc_ptc_pkg::PH_KEY_HI;
               end
               if (cur_key_ff == svc_ptc_pkg::KEY_ALPN) begin
                  if (id_rem_ff == 8'd0) begin
                     // A new identifier must fit in what is left of the value.
                     if ({8'd0, b} > val_dec) begin
                        verdict_in = svc_ptc_pkg::VERDICT_MALFORMED;
                        val_rem_in = val_rem_ff;
                        phase_in   = phase_ff;
                     end else begin
                        id_len_in   = b;
                        id_bytes_in = 24'd0;
                        id_rem_in   = b;
                     end
                  end else begin
                     if ((id_len_ff - id_rem_ff) < 8'd3) begin
                        id_bytes_in = {id_bytes_ff[15:0], b};
                     end
                     id_rem_in = id_dec;
                     if (id_dec == 8'd0) begin
                        tp_in = tp_ff | svc_ptc_pkg::classify_alpn(id_len_ff, id_bytes_in);
                     end
                  end
               end else if (cur_key_ff == svc_ptc_pkg::KEY_PORT) begin
                  port_in = {port_ff[7:0], b};
                  if (val_dec == 16'd0 && {port_ff[7:0], b} == 16'd0) begin
                     verdict_in = svc_ptc_pkg::VERDICT_MALFORMED;
                     phase_in   = phase_ff;
                  end
               end else if (cur_key_ff == svc_ptc_pkg::KEY_DOHPATH) begin
                  if (!svc_ptc_pkg::uri_char_ok(b)) begin
                     verdict_in = svc_ptc_pkg::VERDICT_MALFORMED;
                     val_rem_in = val_rem_ff;
                     phase_in   = phase_ff;
                  end
               end
            end
            default: begin
               cur_key_in = {b, 8'd0};
               phase_in   = svc_ptc_pkg::PH_KEY_LO;
            end
         endcase
      end

      if (fire && item.last_byte) begin
         case (verdict_in)
            svc_ptc_pkg::VERDICT_UNUSABLE:  status = svc_ptc_pkg::STATUS_UNUSABLE;
            svc_ptc_pkg::VERDICT_MALFORMED: status = svc_ptc_pkg::STATUS_MALFORMED;
            default: begin
               if (phase_in != svc_ptc_pkg::PH_KEY_HI || !alpn_seen_in) begin
                  status = svc_ptc_pkg::STATUS_MALFORMED;
               end else if (!path_seen_in && (tp_in & (svc_ptc_pkg::TP_H2 |
                                                      svc_ptc_pkg::TP_H3)) != 4'd0) begin
                  status = svc_ptc_pkg::STATUS_MALFORMED;
               end else if (tp_in == 4'd0) begin
                  status = svc_ptc_pkg::STATUS_UNUSABLE;
               end else begin
                  status = svc_ptc_pkg::STATUS_USABLE;
               end
            end
         endcase
         rsp_load                 = 1'b1;
         rsp_item.status          = status;
         if (status == svc_ptc_pkg::STATUS_USABLE) begin
            rsp_item.transports      = tp_in;
            rsp_item.port            = port_in;
            rsp_item.dohpath_present = path_seen_in;
         end
         // Every option starts from a clean parser.
         phase_in     = svc_ptc_pkg::PH_KEY_HI;
         verdict_in   = svc_ptc_pkg::VERDICT_PARSING;
         cur_key_in   = 16'd0;
         prev_key_in  = 16'd0;
         val_rem_in   = 16'd0;
         id_rem_in    = 8'd0;
         id_bytes_in  = 24'd0;
         id_len_in    = 8'd0;
         tp_in        = 4'd0;
         port_in      = 16'd0;
         alpn_seen_in = 1'b0;
         path_seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= svc_ptc_pkg::PH_KEY_HI;
         verdict_ff   <= svc_ptc_pkg::VERDICT_PARSING;
         cur_key_ff   <= 16'd0;
         prev_key_ff  <= 16'd0;
         val_rem_ff   <= 16'd0;
         id_rem_ff    <= 8'd0;
         id_bytes_ff  <= 24'd0;
         id_len_ff    <= 8'd0;
         tp_ff        <= 4'd0;
         port_ff      <= 16'd0;
         alpn_seen_ff <= 1'b0;
         path_seen_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         verdict_ff   <= verdict_in;
         cur_key_ff   <= cur_key_in;
         prev_key_ff  <= prev_key_in;
         val_rem_ff   <= val_rem_in;
         id_rem_ff    <= id_rem_in;
         id_bytes_ff  <= id_bytes_in;
         id_len_ff    <= id_len_in;
         tp_ff        <= tp_in;
         port_ff      <= port_in;
         alpn_seen_ff <= alpn_seen_in;
         path_seen_ff <= path_seen_in;
      end
   end

endmodule
`default_nettype wire

[design/svc_ptc_out_reg.sv]
// Result register that holds a verdict transaction until the consumer takes it.
`default_nettype none
module svc_ptc_out_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire svc_ptc_pkg::rsp_item_type load_item,
   output logic                           free,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output svc_ptc_pkg::rsp_item_type      rsp_data
);

   logic                      valid_ff, valid_in;
   svc_ptc_pkg::rsp_item_type data_ff;

   // The register can take a new result when empty or when its content leaves now.
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

[design/svc_param_tlv_checker_unit.sv]
// Top level of the DNS SvcParams option checker.
//
//   Channel   Ports                                  Direction  Contents
//   request   req_valid, req_stall, req_data         in         one option byte and flags
//   response  rsp_valid, rsp_stall, rsp_data         out        status, transports, port, dohpath
//
// One byte transaction is taken per cycle while the input register is not stalled; the
// throughput limit is the single parser state update, which is made for every byte.
// A byte waits in the input register until the parser takes it, and the verdict of an option
// appears at the response port on the cycle after its last byte leaves that register.
// Reset is synchronous and active high; it clears the parser and both valid bits.
// A stalled response only holds up the input register when it carries the last byte
// of an option, so bytes inside an option keep flowing while a verdict waits.
`default_nettype none
module svc_param_tlv_checker_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire svc_ptc_pkg::req_item_type req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output svc_ptc_pkg::rsp_item_type      rsp_data
);

   logic                      in_valid_ff, in_valid_in;
   svc_ptc_pkg::req_item_type in_item_ff;
   logic                      in_go;
   logic                      req_take;
   logic                      out_free;
   logic                      res_load;
   svc_ptc_pkg::rsp_item_type res_item;

   // The held transaction moves into the parser unless it ends an option and the
   // result register has no room for the verdict.
   assign in_go     = in_valid_ff && (!in_item_ff.last_byte || out_free);
   assign req_stall = in_valid_ff && !in_go;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !in_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
   end

   svc_ptc_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .fire     (in_go),
      .item     (in_item_ff),
      .rsp_load (res_load),
      .rsp_item (res_item)
   );

   svc_ptc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_load),
      .load_item (res_item),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the SvcParams option checker, with a built-in option predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // A stuck run is one in which neither channel completes a transaction for this many cycles.
   localparam int STUCK_LIMIT = 2000;
   // The long receiver hold-off, in cycles, that backs the checker up into its input.
   localparam int LONG_HOLD   = 120;
   localparam int ITEM_TARGET = 1350;

   // ALPN identifiers that the checker maps to transport bits, right-aligned in 24 bits.
   localparam logic [23:0] ID_DOT = "dot";
   localparam logic [23:0] ID_H2  = "h2";
   localparam logic [23:0] ID_H3  = "h3";
   localparam logic [23:0] ID_DOQ = "doq";

   // Ways in which a generated option is damaged before it is sent.
   typedef enum int {
      FLAW_NONE,
      FLAW_TRUNC,
      FLAW_CORRUPT,
      FLAW_HINT,
      FLAW_PORT,
      FLAW_PATH,
      FLAW_ORDER,
      FLAW_ALPN_LONG,
      FLAW_NO_ALPN,
      FLAW_ZERO_KEY,
      FLAW_NOISE
   } flaw_kind;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   svc_ptc_pkg::req_item_type req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   svc_ptc_pkg::rsp_item_type rsp_data;

   // Byte transactions waiting to be driven, and the verdicts the checker still owes us.
   svc_ptc_pkg::req_item_type byte_feed[$];
   svc_ptc_pkg::rsp_item_type verdicts_due[$];

   // Scratch buffers used while an option is being assembled.
   logic [7:0] opt_bytes[$];
   logic [7:0] val_bytes[$];
   string      uri_pool =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~:/?#[]@!$&'()*+,;={}";

   int mismatch_count  = 0;
   int options_checked = 0;
   int items_shipped   = 0;
   int stuck_cycles    = 0;
   int gap_left        = 0;
   int stall_left      = 0;
   int hold_left       = 0;
   int hold_requests   = 0;
   int hold_served     = 0;
   bit quiet_tail      = 1'b0;

   // Predictor copy of the parser state. It advances once per accepted byte transaction.
   svc_ptc_pkg::phase_type   scan_phase;
   svc_ptc_pkg::verdict_type scan_verdict;
   logic [15:0] scan_key;
   logic [15:0] last_key;
   logic [15:0] bytes_left;
   logic [8:0]  id_left;
   logic [7:0]  id_len;
   logic [23:0] id_tail;
   logic [3:0]  tp_seen;
   logic [15:0] port_acc;
   logic        has_alpn;
   logic        has_path;

   svc_param_tlv_checker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------------------------

   task automatic clear_scan();
      scan_phase   = svc_ptc_pkg::PH_KEY_HI;
      scan_verdict = svc_ptc_pkg::VERDICT_PARSING;
      scan_key     = '0;
      last_key     = '0;
      bytes_left   = '0;
      id_left      = '0;
      id_len       = '0;
      id_tail      = '0;
      tp_seen      = '0;
      port_acc     = '0;
      has_alpn     = 1'b0;
      has_path     = 1'b0;
   endtask

   // Characters allowed in a dohpath value: the URI set plus the template braces.
   function automatic bit uri_allowed(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
             (c inside {"-", ".", "_", "~", ":", "/", "?", "#", "[", "]", "@", "!", "$",
                        "&", "'", "(", ")", "*", "+", ",", ";", "=", "{", "}"});
   endfunction

   // A complete ALPN identifier is held in id_tail; known names add their transport bit.
   task automatic note_alpn_id();
      if (id_len == 8'd3 && id_tail == ID_DOT) tp_seen = tp_seen | svc_ptc_pkg::TP_DOT;
      if (id_len == 8'd2 && id_tail == ID_H2)  tp_seen = tp_seen | svc_ptc_pkg::TP_H2;
      if (id_len == 8'd2 && id_tail == ID_H3)  tp_seen = tp_seen | svc_ptc_pkg::TP_H3;
      if (id_len == 8'd3 && id_tail == ID_DOQ) tp_seen = tp_seen | svc_ptc_pkg::TP_DOQ;
   endtask

   // The length field of a parameter has just completed.
   task automatic close_header();
      if (scan_key == svc_ptc_pkg::KEY_ALPN) begin
         if (bytes_left == 16'd0) begin
            // An empty ALPN value makes the whole option unusable right away.
            scan_verdict = svc_ptc_pkg::VERDICT_UNUSABLE;
            return;
         end
         has_alpn = 1'b1;
         id_left  = '0;
      end else if (scan_key == svc_ptc_pkg::KEY_PORT) begin
         if (bytes_left != 16'd2) begin
            scan_verdict = svc_ptc_pkg::VERDICT_MALFORMED;
            return;
         end
      end else if (scan_key == svc_ptc_pkg::KEY_IPV4HINT ||
                   scan_key == svc_ptc_pkg::KEY_IPV6HINT) begin
         scan_verdict = svc_ptc_pkg::VERDICT_MALFORMED;
         return;
      end else if (scan_key == svc_ptc_pkg::KEY_DOHPATH) begin
         has_path = 1'b1;
      end
      scan_phase = (bytes_left != 16'd0) ? svc_ptc_pkg::PH_VALUE : svc_ptc_pkg::PH_KEY_HI;
   endtask

   task automatic take_value(input logic [7:0] b);
      if (scan_key == svc_ptc_pkg::KEY_ALPN) begin
         if (id_left == 9'd0) begin
            // Length byte of the next identifier; it must fit in the rest of the value.
            if ({8'h00, b} > bytes_left - 16'd1) begin
               scan_verdict = svc_ptc_pkg::VERDICT_MALFORMED;
               return;
            end
            id_len  = b;
            id_tail = '0;
            id_left = {1'b0, b};
            if (b == 8'd0) note_alpn_id();
         end else begin
            // Only the first three bytes of an identifier matter for classification.
            if (({1'b0, id_len} - id_left) < 9'd3) id_tail = {id_tail[15:0], b};
            id_left = id_left - 9'd1;
            if (id_left == 9'd0) note_alpn_id();
         end
      end else if (scan_key == svc_ptc_pkg::KEY_PORT) begin
         port_acc = {port_acc[7:0], b};
      end else if (scan_key == svc_ptc_pkg::KEY_DOHPATH && !uri_allowed(b)) begin
         scan_verdict = svc_ptc_pkg::VERDICT_MALFORMED;
         return;
      end
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) begin
         if (scan_key == svc_ptc_pkg::KEY_PORT && port_acc == 16'd0) begin
            scan_verdict = svc_ptc_pkg::VERDICT_MALFORMED;
            return;
         end
         scan_phase = svc_ptc_pkg::PH_KEY_HI;
      end
   endtask

   task automatic parse_octet(input logic [7:0] b);
      case (scan_phase)
         svc_ptc_pkg::PH_KEY_HI: begin
            scan_key   = {b, 8'h00};
            scan_phase = svc_ptc_pkg::PH_KEY_LO;
         end
         svc_ptc_pkg::PH_KEY_LO: begin
            // Keys must strictly increase from zero, so key zero never passes.
            scan_key[7:0] = b;
            if (scan_key <= last_key) begin
               scan_verdict = svc_ptc_pkg::VERDICT_MALFORMED;
            end else begin
               last_key   = scan_key;
               scan_phase = svc_ptc_pkg::PH_LEN_HI;
            end
         end
         svc_ptc_pkg::PH_LEN_HI: begin
            bytes_left = {b, 8'h00};
            scan_phase = svc_ptc_pkg::PH_LEN_LO;
         end
         svc_ptc_pkg::PH_LEN_LO: begin
            bytes_left[7:0] = b;
            close_header();
         end
         default: begin
            take_value(b);
         end
      endcase
   endtask

   // The option has ended: queue the verdict the checker must give, then start afresh.
   task automatic judge_option();
      svc_ptc_pkg::rsp_item_type due;
      logic [1:0]                st;
      if (scan_verdict == svc_ptc_pkg::VERDICT_UNUSABLE)
         st = svc_ptc_pkg::STATUS_UNUSABLE;
      else if (scan_verdict == svc_ptc_pkg::VERDICT_MALFORMED)
         st = svc_ptc_pkg::STATUS_MALFORMED;
      else if (scan_phase != svc_ptc_pkg::PH_KEY_HI || !has_alpn)
         st = svc_ptc_pkg::STATUS_MALFORMED;
      else if (!has_path && (tp_seen & (svc_ptc_pkg::TP_H2 | svc_ptc_pkg::TP_H3)) != 4'd0)
         st = svc_ptc_pkg::STATUS_MALFORMED;
      else if (tp_seen == 4'd0)
         st = svc_ptc_pkg::STATUS_UNUSABLE;
      else
         st = svc_ptc_pkg::STATUS_USABLE;
      due        = '0;
      due.status = st;
      if (st == svc_ptc_pkg::STATUS_USABLE) begin
         due.transports      = tp_seen;
         due.port            = port_acc;
         due.dohpath_present = has_path;
      end
      verdicts_due.push_back(due);
      clear_scan();
   endtask

   task automatic track_option_byte(input svc_ptc_pkg::req_item_type it);
      // Once a verdict is latched the remaining bytes of the option are ignored.
      if (it.byte_present && scan_verdict == svc_ptc_pkg::VERDICT_PARSING)
         parse_octet(it.data_byte);
      if (it.last_byte) judge_option();
   endtask

   task automatic log_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("MISMATCH at %0t: option %0d %s got 0x%0h, expected 0x%0h",
               $time, options_checked, what, got, want);
   endtask

   // ------------------------------------------------------------------------------------------
   // Request driver: pops byte transactions from the feed, predicts on each acceptance.
   // The payload is only replaced once the previous transaction has been taken.
   // ------------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
         clear_scan();
      end else begin
         if (req_valid && !req_stall) track_option_byte(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_feed.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
               // Idle burst: req_valid drops now and gap_left further idle steps follow.
               gap_left = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= byte_feed.pop_front();
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------------
   // Response stall: short random bursts, plus the long hold-off when the stimulus asks for it.
   // ------------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------------------------
   // Response monitor: every accepted verdict is compared with the oldest prediction.
   // ------------------------------------------------------------------------------------------

   always @(posedge clock) begin
      svc_ptc_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            log_mismatch("verdict with no option pending, status",
                         int'(rsp_data.status), 0);
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_data.status !== want.status)
               log_mismatch("status", int'(rsp_data.status), int'(want.status));
            if (rsp_data.transports !== want.transports)
               log_mismatch("transports", int'(rsp_data.transports), int'(want.transports));
            if (rsp_data.port !== want.port)
               log_mismatch("port", int'(rsp_data.port), int'(want.port));
            if (rsp_data.dohpath_present !== want.dohpath_present)
               log_mismatch("dohpath_present", int'(rsp_data.dohpath_present),
                            int'(want.dohpath_present));
         end
         options_checked++;
      end
   end

   // Watchdog: ends the run if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------------------------

   // Appends one parameter (key, length, value) built from val_bytes to the option.
   task automatic put_param(input logic [15:0] key);
      logic [15:0] len;
      len = 16'(val_bytes.size());
      opt_bytes.push_back(key[15:8]);
      opt_bytes.push_back(key[7:0]);
      opt_bytes.push_back(len[15:8]);
      opt_bytes.push_back(len[7:0]);
      foreach (val_bytes[i]) opt_bytes.push_back(val_bytes[i]);
      val_bytes.delete();
   endtask

   task automatic add_id(input string s);
      val_bytes.push_back(8'(s.len()));
      for (int i = 0; i < s.len(); i++) val_bytes.push_back(s[i]);
   endtask

   task automatic add_junk(input int n);
      repeat (n) val_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Assembles one option into opt_bytes. Keys go out in increasing order, so a flawless
   // option reaches the end-of-option checks; a flaw damages it in one chosen way.
   task automatic build_option(input flaw_kind flaw);
      int          n;
      logic [15:0] p;
      logic [7:0]  b;
      opt_bytes.delete();
      val_bytes.delete();
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(0, 12)) opt_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (flaw == FLAW_ZERO_KEY) begin
         // Key zero would be the mandatory list; the ordering rule rejects it.
         add_junk(2);
         put_param(16'h0000);
      end
      if (flaw == FLAW_HINT) begin
         add_junk(4);
         put_param(($urandom_range(0, 1) == 0) ? svc_ptc_pkg::KEY_IPV4HINT
                                               : svc_ptc_pkg::KEY_IPV6HINT);
      end
      if (flaw != FLAW_NO_ALPN) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 7))
               0: add_id("dot");
               1: add_id("h2");
               2: add_id("h3");
               3: add_id("doq");
               4: add_id("http/1.1");
               5: add_id("dox");
               6: val_bytes.push_back(8'h00);
               default: begin
                  n = $urandom_range(1, 4);
                  val_bytes.push_back(8'(n));
                  add_junk(n);
               end
            endcase
         end
         if (flaw == FLAW_ALPN_LONG) begin
            // Identifier length larger than the two bytes left in the value.
            val_bytes.push_back(8'($urandom_range(3, 255)));
            add_junk(2);
         end
         put_param(svc_ptc_pkg::KEY_ALPN);
      end
      if ($urandom_range(0, 3) == 0) begin
         add_junk($urandom_range(0, 3));
         put_param(16'd2);
      end
      if (flaw == FLAW_PORT) begin
         case ($urandom_range(0, 2))
            0: val_bytes.push_back(8'($urandom_range(1, 255)));
            1: add_junk(3);
            default: begin
               val_bytes.push_back(8'h00);
               val_bytes.push_back(8'h00);
            end
         endcase
         put_param(svc_ptc_pkg::KEY_PORT);
      end else if ($urandom_range(0, 1) == 0) begin
         p = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
         val_bytes.push_back(p[15:8]);
         val_bytes.push_back(p[7:0]);
         put_param(svc_ptc_pkg::KEY_PORT);
      end
      if ($urandom_range(0, 4) == 0) begin
         add_junk($urandom_range(0, 3));
         put_param(16'd5);
      end
      if (flaw == FLAW_PATH || $urandom_range(0, 9) < 6) begin
         n = $urandom_range((flaw == FLAW_PATH) ? 1 : 0, 8);
         repeat (n) val_bytes.push_back(uri_pool[$urandom_range(0, uri_pool.len() - 1)]);
         if (flaw == FLAW_PATH) begin
            b = 8'($urandom_range(0, 255));
            while (uri_allowed(b)) b = 8'($urandom_range(0, 255));
            val_bytes[$urandom_range(0, n - 1)] = b;
         end
         put_param(svc_ptc_pkg::KEY_DOHPATH);
      end
      if ($urandom_range(0, 3) == 0) begin
         add_junk($urandom_range(0, 3));
         put_param(($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(8, 65534)));
      end
      case (flaw)
         FLAW_ORDER: begin
            // ALPN again after it: the key does not increase.
            add_junk($urandom_range(0, 2));
            put_param(svc_ptc_pkg::KEY_ALPN);
         end
         FLAW_TRUNC: begin
            repeat ($urandom_range(1, 4))
               if (opt_bytes.size() != 0) opt_bytes.delete(opt_bytes.size() - 1);
         end
         FLAW_CORRUPT: begin
            if (opt_bytes.size() != 0)
               opt_bytes[$urandom_range(0, opt_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
         default: ;
      endcase
   endtask

   // Moves opt_bytes into the feed. The option ends either on its final byte or on a
   // separate transaction without a byte; idle steps without a byte are sprinkled in.
   task automatic ship_option(input bit trailer);
      int k;
      while (byte_feed.size() > 16) @(negedge clock);
      for (k = 0; k < opt_bytes.size(); k++) begin
         if ($urandom_range(0, 24) == 0)
            byte_feed.push_back(svc_ptc_pkg::req_item_type'{8'($urandom_range(0, 255)),
                                                            1'b0, 1'b0});
         byte_feed.push_back(svc_ptc_pkg::req_item_type'{opt_bytes[k], 1'b1,
                                                         !trailer && k == opt_bytes.size() - 1});
      end
      items_shipped += opt_bytes.size();
      if (trailer || opt_bytes.size() == 0) begin
         byte_feed.push_back(svc_ptc_pkg::req_item_type'{8'($urandom_range(0, 255)),
                                                         1'b0, 1'b1});
         items_shipped++;
      end
   endtask

   // Holds the sender until every byte is taken and every predicted verdict has come back.
   task automatic settle_all();
      @(negedge clock);
      while (byte_feed.size() != 0 || req_valid || verdicts_due.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------------------------

   initial begin
      bit       hold_fired;
      bit       pause_done;
      int       pick;
      flaw_kind flaw;
      hold_fired = 1'b0;
      pause_done = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed options. An empty option has no ALPN and is malformed.
      opt_bytes.delete();
      ship_option(1'b0);
      // Key zero is rejected by the ordering rule.
      opt_bytes = '{8'h00, 8'h00};
      ship_option(1'b0);
      // Empty ALPN value: unusable at once, and the extreme byte after it is ignored.
      opt_bytes = '{8'h00, 8'h01, 8'h00, 8'h00, 8'hFF};
      ship_option(1'b0);
      // A step with neither a byte nor an end changes nothing.
      byte_feed.push_back(svc_ptc_pkg::req_item_type'{8'hA5, 1'b0, 1'b0});
      // Smallest usable option, closed by a transaction that carries no byte.
      opt_bytes = '{8'h00, 8'h01, 8'h00, 8'h04, 8'h03, "d", "o", "t"};
      ship_option(1'b1);
      // Largest key, then the option ends inside the parameter header.
      opt_bytes = '{8'hFF, 8'hFF};
      ship_option(1'b0);
      settle_all();

      // Random options: mostly well formed with random content, the rest damaged or noise.
      while (items_shipped < ITEM_TARGET) begin
         if (!hold_fired && items_shipped >= 450) begin
            // The receiver holds off for a long stretch while bytes keep coming.
            hold_requests++;
            hold_fired = 1'b1;
         end
         if (!pause_done && items_shipped >= 850) begin
            settle_all();
            pause_done = 1'b1;
         end
         if (items_shipped >= ITEM_TARGET - 150) quiet_tail = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 60)
            flaw = FLAW_NONE;
         else if (pick < 92)
            flaw = flaw_kind'($urandom_range(FLAW_TRUNC, FLAW_ZERO_KEY));
         else
            flaw = FLAW_NOISE;
         build_option(flaw);
         ship_option($urandom_range(0, 4) == 0);
      end

      settle_all();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
design/svc_ptc_pkg.sv
design/svc_ptc_parser.sv
design/svc_ptc_out_reg.sv
design/svc_param_tlv_checker_unit.sv
bench/tb_top.sv
